// ===== design/hwc_pkg.sv =====
// ----------------------------------------------------------------------------
// hwc_pkg
// Shared types and constants for the heatmap window crop unit.
// ----------------------------------------------------------------------------
package hwc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 11;

  localparam int unsigned MAX_ANGLE_BINS_DEF = 256;
  localparam int unsigned MAX_RANGE_BINS_DEF = 1024;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_AZ_BINS = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_EL_BINS = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_RG_BINS = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_AZ_HALF = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_EL_HALF = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_RG_LIM  = 3'd5;

  // reset values
  localparam logic [8:0]         RST_AZ_BINS = 9'd128;
  localparam logic [8:0]         RST_EL_BINS = 9'd32;
  localparam logic [10:0]        RST_RG_BINS = 11'd128;
  localparam logic signed [8:0]  RST_AZ_HALF = -9'sd1;
  localparam logic signed [8:0]  RST_EL_HALF = -9'sd1;
  localparam logic signed [10:0] RST_RG_LIM  = -11'sd1;

  typedef struct packed {
    logic [8:0]         az_bins;
    logic [8:0]         el_bins;
    logic [10:0]        rg_bins;
    logic signed [8:0]  az_half;
    logic signed [8:0]  el_half;
    logic signed [10:0] rg_lim;
  } hwc_cfg_t;

  typedef struct packed {
    logic              keep;
    logic              last;
    logic [WORD_W-1:0] word;
  } hwc_item_t;

endpackage

// ===== design/hwc_cfg.sv =====
// ----------------------------------------------------------------------------
// hwc_cfg
// Configuration register file, one write per cycle, unknown indexes ignored.
// ----------------------------------------------------------------------------
module hwc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hwc_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hwc_pkg::CFG_DW-1:0] cfg_data_i,
  output hwc_pkg::hwc_cfg_t         cfg_o
);

  hwc_pkg::hwc_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        hwc_pkg::CFG_AZ_BINS: cfg_d.az_bins = cfg_data_i[8:0];
        hwc_pkg::CFG_EL_BINS: cfg_d.el_bins = cfg_data_i[8:0];
        hwc_pkg::CFG_RG_BINS: cfg_d.rg_bins = cfg_data_i;
        hwc_pkg::CFG_AZ_HALF: cfg_d.az_half = cfg_data_i[8:0];
        hwc_pkg::CFG_EL_HALF: cfg_d.el_half = cfg_data_i[8:0];
        hwc_pkg::CFG_RG_LIM:  cfg_d.rg_lim  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.az_bins <= hwc_pkg::RST_AZ_BINS;
      cfg_q.el_bins <= hwc_pkg::RST_EL_BINS;
      cfg_q.rg_bins <= hwc_pkg::RST_RG_BINS;
      cfg_q.az_half <= hwc_pkg::RST_AZ_HALF;
      cfg_q.el_half <= hwc_pkg::RST_EL_HALF;
      cfg_q.rg_lim  <= hwc_pkg::RST_RG_LIM;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/hwc_track.sv =====
// ----------------------------------------------------------------------------
// hwc_track
// Position counters, window bounds and in-window test; registers one item.
// ----------------------------------------------------------------------------
module hwc_track #(
  parameter int unsigned MAX_ANGLE_BINS = hwc_pkg::MAX_ANGLE_BINS_DEF,
  parameter int unsigned MAX_RANGE_BINS = hwc_pkg::MAX_RANGE_BINS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hwc_pkg::hwc_cfg_t          cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hwc_pkg::WORD_W-1:0] in_word_i,
  input  logic                       pop_i,
  output logic                       s1_valid_o,
  output hwc_pkg::hwc_item_t         s1_item_o
);

  // counter widths, effective bin count widths, work widths
  localparam int unsigned AW  = (MAX_ANGLE_BINS > 1) ? $clog2(MAX_ANGLE_BINS) : 1;
  localparam int unsigned RW  = (MAX_RANGE_BINS > 1) ? $clog2(MAX_RANGE_BINS) : 1;
  localparam int unsigned NAW = $clog2(MAX_ANGLE_BINS + 1);
  localparam int unsigned NRW = $clog2(MAX_RANGE_BINS + 1);
  localparam int unsigned AXW = ((NAW > 10) ? NAW : 10) + 1;
  localparam int unsigned RXW = ((NRW > 11) ? NRW : 11) + 1;

  function automatic logic [NAW-1:0] eff_angle(input logic [8:0] n);
    logic [31:0] n32;
    n32 = 32'(n);
    if (n32 == 32'd0) return NAW'(1);
    if (n32 > 32'(MAX_ANGLE_BINS)) return NAW'(MAX_ANGLE_BINS);
    return NAW'(n32);
  endfunction

  function automatic logic [NRW-1:0] eff_range(input logic [10:0] n);
    logic [31:0] n32;
    n32 = 32'(n);
    if (n32 == 32'd0) return NRW'(1);
    if (n32 > 32'(MAX_RANGE_BINS)) return NRW'(MAX_RANGE_BINS);
    return NRW'(n32);
  endfunction

  // centred window of 2*h+2 bins, whole axis when the request is rejected
  function automatic void angle_win(input  logic [NAW-1:0]   n,
                                    input  logic signed [8:0] req,
                                    output logic [AW-1:0]     lo,
                                    output logic [AW-1:0]     hi);
    logic [AXW-1:0] half, req_x, span;
    half  = AXW'(n >> 1);
    req_x = AXW'(req[7:0]);
    span  = (req_x + AXW'(1)) << 1;
    if (!req[8] && (span < AXW'(n))) begin
      lo = AW'(half - AXW'(1) - req_x);
      hi = AW'(half + req_x);
    end else begin
      lo = '0;
      hi = AW'(AXW'(n) - AXW'(1));
    end
  endfunction

  logic [NAW-1:0] na, ne;
  logic [NRW-1:0] nr;
  logic [AW-1:0]  alo, ahi, elo, ehi, a_last, e_last;
  logic [RW-1:0]  rhi, r_last;

  logic [AW-1:0]  elev_q, elev_d, azim_q, azim_d;
  logic [RW-1:0]  range_q, range_d;
  logic           pair_q, pair_d;

  logic               s1_valid_q;
  hwc_pkg::hwc_item_t s1_item_q, s1_item_d;
  logic               accept, keep, last;

  always_comb begin
    na = eff_angle(cfg_i.az_bins);
    ne = eff_angle(cfg_i.el_bins);
    nr = eff_range(cfg_i.rg_bins);
    angle_win(na, cfg_i.az_half, alo, ahi);
    angle_win(ne, cfg_i.el_half, elo, ehi);
    a_last = AW'(AXW'(na) - AXW'(1));
    e_last = AW'(AXW'(ne) - AXW'(1));
    r_last = RW'(RXW'(nr) - RXW'(1));
    if (!cfg_i.rg_lim[10] && (RXW'(cfg_i.rg_lim[9:0]) < RXW'(nr))) begin
      rhi = RW'(RXW'(cfg_i.rg_lim[9:0]));
    end else begin
      rhi = r_last;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || pop_i;

  assign keep = (elev_q >= elo) && (elev_q <= ehi) && (azim_q >= alo) &&
                (azim_q <= ahi) && (range_q <= rhi);
  assign last = (elev_q == ehi) && (azim_q == ahi) && (range_q == rhi) && pair_q;

  // intensity then doppler; range, azimuth, elevation carry in turn
  always_comb begin
    elev_d  = elev_q;
    azim_d  = azim_q;
    range_d = range_q;
    pair_d  = pair_q;
    if (accept) begin
      pair_d = !pair_q;
      if (pair_q) begin
        if (range_q >= r_last) begin
          range_d = '0;
          if (azim_q >= a_last) begin
            azim_d = '0;
            elev_d = (elev_q >= e_last) ? '0 : elev_q + AW'(1);
          end else begin
            azim_d = azim_q + AW'(1);
          end
        end else begin
          range_d = range_q + RW'(1);
        end
      end
    end
  end

  always_comb begin
    s1_item_d.keep = keep;
    s1_item_d.last = last;
    s1_item_d.word = in_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elev_q     <= '0;
      azim_q     <= '0;
      range_q    <= '0;
      pair_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      elev_q  <= elev_d;
      azim_q  <= azim_d;
      range_q <= range_d;
      pair_q  <= pair_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (pop_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= s1_item_d;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_item_o  = s1_item_q;

endmodule

// ===== design/heatmap_window_crop_unit.sv =====
// ----------------------------------------------------------------------------
// heatmap_window_crop_unit
// Passes the heatmap words that fall inside an elevation/azimuth/range window.
// ----------------------------------------------------------------------------
// Path: tracking register, then output register for a kept word, then m_axis.
// Throughput: one word per cycle; the counters and bound compares sit between
//   the input port and the tracking register, so only a kept word blocked at
//   the output register stalls the input.
// Reset: async active low; counters go to zero, registers to their defaults
//   (128 x 32 x 128 bins, full window on every axis), both stages empty.
module heatmap_window_crop_unit #(
  parameter int unsigned MAX_ANGLE_BINS = hwc_pkg::MAX_ANGLE_BINS_DEF,
  parameter int unsigned MAX_RANGE_BINS = hwc_pkg::MAX_RANGE_BINS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hwc_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [hwc_pkg::CFG_DW-1:0] cfg_data_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [hwc_pkg::WORD_W-1:0] s_axis_tdata,   // [31:0] word_in
  // output stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [hwc_pkg::WORD_W-1:0] m_axis_tdata,   // [31:0] word_out
  output logic                       m_axis_tlast    // frame_last
);

  hwc_pkg::hwc_cfg_t  cfg;
  hwc_pkg::hwc_item_t s1_item;
  logic               s1_valid;
  logic               s1_pop;
  logic               out_free;

  logic                       m_valid_q;
  logic [hwc_pkg::WORD_W-1:0] m_word_q;
  logic                       m_last_q;

  hwc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hwc_track #(
    .MAX_ANGLE_BINS (MAX_ANGLE_BINS),
    .MAX_RANGE_BINS (MAX_RANGE_BINS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_word_i  (s_axis_tdata),
    .pop_i      (s1_pop),
    .s1_valid_o (s1_valid),
    .s1_item_o  (s1_item)
  );

  // Output register frees when empty or drained this cycle. A dropped item
  // leaves the tracking stage at once; a kept one waits for a free slot.
  assign out_free = !m_valid_q || m_axis_tready;
  assign s1_pop   = s1_valid && (!s1_item.keep || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_pop && s1_item.keep) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_pop && s1_item.keep) begin
      m_word_q <= s1_item.word;
      m_last_q <= s1_item.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_word_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  // input backpressure only when the tracking stage holds a word it cannot pass on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (s1_valid && s1_item.keep && !out_free))
    else $error("input stalled without a blocked kept word");

  // an accepted word always lands in the tracking stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> s1_valid)
    else $error("accepted word lost before tracking stage");

  // a kept word moved on shows up unchanged on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_pop && s1_item.keep) |=>
      (m_axis_tvalid && (m_axis_tdata == $past(s1_item.word))))
    else $error("kept word not presented on output");
`endif

endmodule

// ===== tb/sv/heatmap_window_crop_unit_tb.sv =====
// ----------------------------------------------------------------------------
// heatmap_window_crop_unit_tb
// Self-checking bench for the heatmap window crop unit. A queue-fed driver
// streams heatmap words, a clocked monitor tracks the bin position of every
// accepted word and predicts which ones survive the crop, and each kept word
// and its frame-end flag are checked in order. Bin counts and window requests
// are rewritten between phases, including zero, odd, oversized and rejected
// settings.
// ----------------------------------------------------------------------------
module heatmap_window_crop_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET   = 1250;
  localparam int unsigned SETTLE_CYCLES = 6;    // output lags input by the tracking and output registers
  localparam logic [hwc_pkg::CFG_IW-1:0] NO_SUCH_REG = hwc_pkg::CFG_RG_LIM + 3'd1;

  typedef struct packed {
    logic [hwc_pkg::WORD_W-1:0] word;
    logic                       last;
  } kept_word_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_valid_i   = 1'b0;
  logic                       cfg_ready_o;
  logic [hwc_pkg::CFG_IW-1:0] cfg_idx_i     = '0;
  logic [hwc_pkg::CFG_DW-1:0] cfg_data_i    = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [hwc_pkg::WORD_W-1:0] s_axis_tdata  = '0;   // [31:0] word_in
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b1;
  logic [hwc_pkg::WORD_W-1:0] m_axis_tdata;         // [31:0] word_out
  logic                       m_axis_tlast;         // frame_last

  heatmap_window_crop_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the registers, updated when a write is accepted
  int unsigned az_bins_r = int'(hwc_pkg::RST_AZ_BINS);
  int unsigned el_bins_r = int'(hwc_pkg::RST_EL_BINS);
  int unsigned rg_bins_r = int'(hwc_pkg::RST_RG_BINS);
  int          az_half_r = int'(hwc_pkg::RST_AZ_HALF);
  int          el_half_r = int'(hwc_pkg::RST_EL_HALF);
  int          rg_lim_r  = int'(hwc_pkg::RST_RG_LIM);

  // position of the next word: elevation, azimuth, range, doppler half
  int  elev_at = 0;
  int  azim_at = 0;
  int  rng_at  = 0;
  bit  dop_at  = 1'b0;

  logic [hwc_pkg::WORD_W-1:0] heatmap_q[$];   // words waiting for the driver
  kept_word_t                 kept_q[$];      // words the crop should let through

  int unsigned feed_gap       = 0;
  int unsigned feed_idle_max  = 0;
  int unsigned drain_wait     = 0;
  int unsigned drain_idle_max = 0;
  bit          feed_fire      = 1'b0;
  bit          drain_fire     = 1'b0;
  int unsigned mismatches     = 0;
  int unsigned sent           = 0;
  int unsigned phases         = 0;

  // append one word to the driver's queue
  task automatic queue_word(input logic [hwc_pkg::WORD_W-1:0] w);
    heatmap_q = {heatmap_q, w};
  endtask

  function automatic int clamp_bins(int unsigned n, int unsigned cap);
    if (n == 0) return 1;
    if (n > cap) return cap;
    return n;
  endfunction

  // centred window of 2*req+2 bins; a rejected request keeps the axis whole
  function automatic void angle_bounds(input int n, input int req, output int lo,
                                       output int hi);
    if (req >= 0 && (req + 1) * 2 < n) begin
      lo = n / 2 - 1 - req;
      hi = n / 2 + req;
    end else begin
      lo = 0;
      hi = n - 1;
    end
  endfunction

  task automatic apply_register(input logic [hwc_pkg::CFG_IW-1:0] idx,
                                input logic [hwc_pkg::CFG_DW-1:0] data);
    case (idx)
      hwc_pkg::CFG_AZ_BINS: az_bins_r = int'(data[8:0]);
      hwc_pkg::CFG_EL_BINS: el_bins_r = int'(data[8:0]);
      hwc_pkg::CFG_RG_BINS: rg_bins_r = int'(data);
      hwc_pkg::CFG_AZ_HALF: az_half_r = int'($signed(data[8:0]));
      hwc_pkg::CFG_EL_HALF: el_half_r = int'($signed(data[8:0]));
      hwc_pkg::CFG_RG_LIM:  rg_lim_r  = int'($signed(data));
      default: ;  // unmapped index, dropped
    endcase
  endtask

  // decide whether this word is kept, then step the position counters
  task automatic crop_word(input logic [hwc_pkg::WORD_W-1:0] w);
    int na, ne, nr, alo, ahi, elo, ehi, rhi;
    kept_word_t kw;
    na = clamp_bins(az_bins_r, hwc_pkg::MAX_ANGLE_BINS_DEF);
    ne = clamp_bins(el_bins_r, hwc_pkg::MAX_ANGLE_BINS_DEF);
    nr = clamp_bins(rg_bins_r, hwc_pkg::MAX_RANGE_BINS_DEF);
    angle_bounds(na, az_half_r, alo, ahi);
    angle_bounds(ne, el_half_r, elo, ehi);
    rhi = (rg_lim_r >= 0 && rg_lim_r < nr) ? rg_lim_r : nr - 1;
    if (elev_at >= elo && elev_at <= ehi && azim_at >= alo && azim_at <= ahi &&
        rng_at <= rhi) begin
      kw.word = w;
      kw.last = (elev_at == ehi && azim_at == ahi && rng_at == rhi && dop_at);
      kept_q  = {kept_q, kw};
    end
    if (!dop_at) begin
      dop_at = 1'b1;
    end else begin
      dop_at = 1'b0;
      // a counter left past a shrunken axis falls back to 0 on its next step
      if (rng_at + 1 >= nr) begin
        rng_at = 0;
        if (azim_at + 1 >= na) begin
          azim_at = 0;
          elev_at = (elev_at + 1 >= ne) ? 0 : elev_at + 1;
        end else begin
          azim_at++;
        end
      end else begin
        rng_at++;
      end
    end
  endtask

  // monitor: register writes, input items and output items at the rising edge
  always @(posedge clk_i) begin
    kept_word_t want;
    feed_fire  <= rst_ni && s_axis_tvalid && s_axis_tready;
    drain_fire <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (kept_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item word %h last %b", $realtime, m_axis_tdata,
                     m_axis_tlast);
        end else begin
          want = kept_q.pop_front();
          if (m_axis_tdata !== want.word || m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: word exp %h got %h, last exp %b got %b", $realtime,
                       want.word, m_axis_tdata, want.last, m_axis_tlast);
          end
        end
      end
      // an item taken on the same edge as a write still sees the old settings
      if (s_axis_tvalid && s_axis_tready) crop_word(s_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) apply_register(cfg_idx_i, cfg_data_i);
    end
  end

  // driver: holds an item until taken, then idles a drawn number of cycles
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || feed_fire) begin
      if (feed_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        feed_gap      <= feed_gap - 1;
      end else if (heatmap_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= heatmap_q.pop_front();
        feed_gap      <= $urandom_range(0, feed_idle_max);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: after each item taken, stall a drawn number of cycles
  always @(negedge clk_i) begin
    if (drain_fire) drain_wait = $urandom_range(0, drain_idle_max);
    if (drain_wait != 0) begin
      m_axis_tready <= 1'b0;
      drain_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [hwc_pkg::CFG_IW-1:0] idx,
                           input logic [hwc_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the driver is empty and every kept word is out, then let
  // words that produce nothing clear the pipe
  task automatic drain_pipeline();
    do @(posedge clk_i); while (heatmap_q.size() != 0 || s_axis_tvalid || kept_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [hwc_pkg::CFG_DW-1:0] az_b, el_b, rg_b, az_h, el_h,
                           rg_l);
    int unsigned frame, n;
    drain_pipeline();
    feed_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 7;
    drain_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
    write_reg(hwc_pkg::CFG_AZ_BINS, az_b);
    write_reg(hwc_pkg::CFG_EL_BINS, el_b);
    write_reg(hwc_pkg::CFG_RG_BINS, rg_b);
    write_reg(hwc_pkg::CFG_AZ_HALF, az_h);
    write_reg(hwc_pkg::CFG_EL_HALF, el_h);
    write_reg(hwc_pkg::CFG_RG_LIM,  rg_l);
    if (phases == 0 || $urandom_range(0, 3) == 0)
      write_reg(3'(NO_SUCH_REG + $urandom_range(0, 1)), 11'($urandom_range(0, 2047)));
    // one whole frame and a few words more where the frame is short
    frame = clamp_bins(az_bins_r, hwc_pkg::MAX_ANGLE_BINS_DEF) *
            clamp_bins(el_bins_r, hwc_pkg::MAX_ANGLE_BINS_DEF) *
            clamp_bins(rg_bins_r, hwc_pkg::MAX_RANGE_BINS_DEF) * 2;
    n = (frame <= 600) ? frame + $urandom_range(0, 16) : $urandom_range(24, 300);
    // keep the total close to the item budget
    if (sent + n > ITEM_TARGET)
      n = (sent + 24 < ITEM_TARGET) ? ITEM_TARGET - sent : 24;
    repeat (n) queue_word($urandom());
    sent += n;
    phases++;
  endtask

  initial begin
    int unsigned az_raw, el_raw, rg_raw, pick;
    logic [hwc_pkg::CFG_DW-1:0] az_b, el_b, rg_b, az_h, el_h, rg_l;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, full window: bit extremes all pass straight through
    queue_word(32'h0000_0000);
    queue_word(32'hFFFF_FFFF);
    queue_word(32'h8000_0000);
    queue_word(32'h7FFF_FFFF);
    queue_word(32'hAAAA_AAAA);
    queue_word(32'h5555_5555);
    queue_word(32'h0000_0001);
    queue_word(32'hFFFF_FFFE);

    // azimuth window one bin wide each side of centre, range cut at bin 1
    run_phase(11'd4, 11'd2, 11'd3, 11'd0, 11'h7FF, 11'd1);
    // all counts zero: treated as one bin, every doppler word ends a frame
    run_phase(11'd0, 11'd0, 11'd0, 11'h1FF, 11'h1FF, 11'h7FF);
    // oversized azimuth count saturates, request at the limit is rejected
    run_phase(11'h7FE, 11'd1, 11'd1, 11'd127, 11'd0, 11'd0);
    // odd bin counts, range request past the axis
    run_phase(11'd5, 11'd3, 11'd2, 11'd1, 11'd0, 11'd5);
    // largest half request, half request whose window spans the axis, most negative limit
    run_phase(11'd8, 11'd6, 11'd2, 11'd255, 11'd2, 11'h400);
    // most negative elevation request
    run_phase(11'd6, 11'd4, 11'd3, 11'd1, 11'h100, 11'd0);
    // oversized range count, largest range request
    run_phase(11'd2, 11'd2, 11'h7FF, 11'd0, 11'd0, 11'd1023);

    while (sent < ITEM_TARGET) begin
      pick   = $urandom_range(0, 19);
      az_raw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 511) : $urandom_range(1, 6);
      pick   = $urandom_range(0, 19);
      el_raw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(7, 511) : $urandom_range(1, 6);
      pick   = $urandom_range(0, 19);
      rg_raw = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(5, 2047) : $urandom_range(1, 4);
      // upper data bits of the 9-bit registers are don't-care
      az_b = 11'(az_raw | ($urandom_range(0, 3) << 9));
      el_b = 11'(el_raw | ($urandom_range(0, 3) << 9));
      rg_b = 11'(rg_raw);
      az_h = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2047)) :
             11'($urandom_range(0, clamp_bins(az_raw, hwc_pkg::MAX_ANGLE_BINS_DEF) / 2));
      el_h = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2047)) :
             11'($urandom_range(0, clamp_bins(el_raw, hwc_pkg::MAX_ANGLE_BINS_DEF) / 2));
      rg_l = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2047)) :
             11'($urandom_range(0, clamp_bins(rg_raw, hwc_pkg::MAX_RANGE_BINS_DEF)));
      run_phase(az_b, el_b, rg_b, az_h, el_h, rg_l);
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("heatmap_window_crop_unit test passed");
    end else begin
      $display("heatmap_window_crop_unit test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("heatmap_window_crop_unit test failed");
    $finish;
  end

endmodule
